>>> rtl/gcfr_pkg.sv
`default_nettype none

package gcfr_pkg;

    localparam int LEVEL_W    = 16;
    localparam int FRAC_W     = 16;
    localparam int FIX_W      = LEVEL_W + FRAC_W;
    localparam int DUR_W      = 16;
    localparam int DUTY_W     = 20;
    localparam int CMD_W      = 2;
    localparam int DIVIDEND_W = FIX_W;
    localparam int DIVISOR_W  = DUR_W;

    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FADE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET  = 2'd2;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/gcfr_gamma_rom.sv
`default_nettype none

module gcfr_gamma_rom #(
    parameter int INDEX_BITS = 10
) (
    input  wire logic                         clk,
    input  wire logic [INDEX_BITS-1:0]        addr,
    output logic      [gcfr_pkg::DUTY_W-1:0] data
);

    localparam int DEPTH = 1 << INDEX_BITS;
    localparam int WIDE  = 320;

    typedef logic [gcfr_pkg::DUTY_W-1:0] rom_t [DEPTH];

    function automatic logic [gcfr_pkg::DUTY_W-1:0] gamma_entry(input int unsigned idx);
        logic [WIDE-1:0] rhs;
        logic [WIDE-1:0] den;
        logic [WIDE-1:0] t;
        logic [20:0]     lo;
        logic [20:0]     hi;
        logic [20:0]     mid;
        int              k;
        int              j;
        rhs = WIDE'(1);
        den = WIDE'(1);
        lo  = 21'd0;
        hi  = 21'd1000000;
        for (k = 0; k < 5; k++)
        begin
            rhs = rhs * WIDE'(1000000);
        end
        for (k = 0; k < 11; k++)
        begin
            rhs = rhs * WIDE'(idx);
            den = den * WIDE'(DEPTH - 1);
        end
        for (j = 0; j < 21; j++)
        begin
            if (lo < hi)
            begin
                mid = lo + ((hi - lo + 21'd1) >> 1);
                t = den;
                for (k = 0; k < 5; k++)
                begin
                    t = t * WIDE'(mid);
                end
                if (t <= rhs)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - 21'd1;
                end
            end
        end
        return lo[gcfr_pkg::DUTY_W-1:0];
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        int   i;
        for (i = 0; i < DEPTH; i++)
        begin
            r[INDEX_BITS'(i)] = gamma_entry(i);
        end
        return r;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [gcfr_pkg::DUTY_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= ROM[addr];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

>>> rtl/gcfr_divider.sv
`default_nettype none

module gcfr_divider (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gcfr_pkg::div_req_t req,
    output gcfr_pkg::div_rsp_t      rsp
);

    localparam int DW = gcfr_pkg::DIVIDEND_W;
    localparam int VW = gcfr_pkg::DIVISOR_W;
    localparam int CW = $clog2(DW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] div_reg;

    logic [VW:0]   trial;
    logic [VW:0]   diff_next;
    logic          fits;

    assign trial     = {rem_reg, quo_reg[DW-1]};
    assign diff_next = trial - {1'b0, div_reg};
    assign fits      = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(DW - 1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            div_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= fits ? diff_next[VW-1:0] : trial[VW-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

>>> rtl/gamma_corrected_fade_ramp.sv
// Brightness fader for a PWM backlight with gamma 2.2 correction.
// Input stream: s_axis_tuser carries the command (tick, fade, set), s_axis_tdata
// carries the level and the fade duration in ms. Every accepted word gives exactly
// one output word on m_axis: the gamma corrected duty in millionths and a flag that
// is high while a fade is still running.
// A tick, a set or an unused command passes from acceptance through ST_LOOKUP (the
// gamma ROM read) to ST_EMIT, which loads the output register once it is free.
// A fade command passes through ST_PREP for the step count (a reciprocal multiply),
// ST_DIV to start the divider, ST_DIV_WAIT while the bit-serial divider works out the
// per-tick delta and to take the delta, then ST_LOOKUP for the gamma ROM read and
// ST_EMIT to load the output register.
// One item is worked at a time; s_axis_tready is high only between items.
// The output register holds a finished word while m_axis_tready is low, and the
// next input word is still accepted; its result waits until the register frees.
// Reset clears the level, goal, delta and fade flag, so a first tick or unused command
// reports duty zero with no fade.
`default_nettype none

module gamma_corrected_fade_ramp #(
    parameter int STEP_PERIOD_MS   = 20,
    parameter int GAMMA_INDEX_BITS = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // level_value[15:0], duration_ms[31:16]
    input  wire logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // duty[19:0], fading[20], zero[23:21]
);

    localparam int LW  = gcfr_pkg::LEVEL_W;
    localparam int FW  = gcfr_pkg::FRAC_W;
    localparam int XW  = gcfr_pkg::FIX_W;
    localparam int DRW = gcfr_pkg::DUR_W;
    localparam int DTW = gcfr_pkg::DUTY_W;
    localparam int RECIP_SHIFT = DRW + $clog2(STEP_PERIOD_MS);
    localparam int RECIP = ((1 << RECIP_SHIFT) + STEP_PERIOD_MS - 1) / STEP_PERIOD_MS;
    localparam int RW  = DRW + 1;
    localparam int PW  = DRW + RW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_DIV_WAIT,
        ST_LOOKUP,
        ST_EMIT
    } state_t;

    state_t                    state_reg;
    logic [XW-1:0]             level_reg;
    logic [LW-1:0]             goal_reg;
    logic signed [XW:0]        delta_reg;
    logic                      active_reg;
    logic [DRW-1:0]            dur_reg;
    logic signed [XW:0]        diff_reg;
    logic [XW-1:0]             mag_reg;
    logic                      neg_reg;
    logic [DRW-1:0]            steps_reg;
    logic                      out_valid_reg;
    logic [DTW-1:0]            out_duty_reg;
    logic                      out_fading_reg;

    logic [1:0]                cmd;
    logic [LW-1:0]             level_value;
    logic [DRW-1:0]            duration_ms;
    logic                      accept;
    logic                      out_free;
    logic signed [XW+1:0]      tick_sum;
    logic signed [XW+1:0]      goal_fx;
    logic                      reached;
    logic signed [XW+1:0]      fade_diff;
    logic [PW-1:0]             product;
    logic [PW-1:0]             steps_full;
    logic [XW-1:0]             quo_fix;
    logic [DTW-1:0]            rom_data;
    gcfr_pkg::div_req_t        div_req;
    gcfr_pkg::div_rsp_t        div_rsp;

    assign cmd         = s_axis_tuser;
    assign level_value = s_axis_tdata[LW-1:0];
    assign duration_ms = s_axis_tdata[LW+DRW-1:LW];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign goal_fx  = {2'b00, goal_reg, {FW{1'b0}}};
    assign tick_sum = $signed({2'b00, level_reg}) + {delta_reg[XW], delta_reg};
    assign reached  = delta_reg[XW] ? (tick_sum <= goal_fx) : (tick_sum >= goal_fx);

    assign fade_diff = $signed({2'b00, level_value, {FW{1'b0}}}) - $signed({2'b00, level_reg});

    assign product    = {{RW{1'b0}}, dur_reg} * PW'(RECIP);
    assign steps_full = product >> RECIP_SHIFT;

    assign quo_fix = ((div_rsp.quotient == '0) && (mag_reg != '0)) ? XW'(1) : div_rsp.quotient;

    assign div_req.start    = (state_reg == ST_DIV);
    assign div_req.dividend = mag_reg;
    assign div_req.divisor  = steps_reg;

    gcfr_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    gcfr_gamma_rom #(
        .INDEX_BITS (GAMMA_INDEX_BITS)
    ) u_rom (
        .clk  (clk),
        .addr (level_reg[XW-1 -: GAMMA_INDEX_BITS]),
        .data (rom_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            level_reg      <= '0;
            goal_reg       <= '0;
            delta_reg      <= '0;
            active_reg     <= 1'b0;
            dur_reg        <= '0;
            diff_reg       <= '0;
            mag_reg        <= '0;
            neg_reg        <= 1'b0;
            steps_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_duty_reg   <= '0;
            out_fading_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= (cmd == gcfr_pkg::CMD_FADE) ? ST_PREP : ST_LOOKUP;
                        case (cmd)
                            gcfr_pkg::CMD_FADE:
                            begin
                                goal_reg  <= level_value;
                                dur_reg   <= duration_ms;
                                diff_reg  <= fade_diff[XW:0];
                            end
                            gcfr_pkg::CMD_SET:
                            begin
                                goal_reg   <= level_value;
                                level_reg  <= {level_value, {FW{1'b0}}};
                                active_reg <= 1'b0;
                            end
                            gcfr_pkg::CMD_TICK:
                            begin
                                if (active_reg)
                                begin
                                    if (reached)
                                    begin
                                        level_reg  <= {goal_reg, {FW{1'b0}}};
                                        active_reg <= 1'b0;
                                    end
                                    else
                                    begin
                                        level_reg <= tick_sum[XW-1:0];
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_PREP:
                begin
                    steps_reg <= (steps_full[DRW-1:0] == '0) ? DRW'(1) : steps_full[DRW-1:0];
                    neg_reg   <= diff_reg[XW];
                    mag_reg   <= diff_reg[XW] ? XW'(-diff_reg) : diff_reg[XW-1:0];
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        delta_reg  <= neg_reg ? -$signed({1'b0, quo_fix})
                                              : $signed({1'b0, quo_fix});
                        active_reg <= 1'b1;
                        state_reg  <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_duty_reg   <= rom_data;
                        out_fading_reg <= active_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_fading_reg, out_duty_reg};

endmodule

`default_nettype wire

>>> verif/fade_ramp_checker.sv
`timescale 1ns / 100ps

module fade_ramp_checker
    import gcfr_pkg::*;
#(
    parameter int STEP_PERIOD_MS   = 20,
    parameter int GAMMA_INDEX_BITS = 10
) (
    input  logic        clk,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    output int          mismatches,
    output int          outstanding
);

    localparam int LUT_DEPTH = 1 << GAMMA_INDEX_BITS;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              fading;
    } fade_word_t;

    logic [DUTY_W-1:0] duty_lut [LUT_DEPTH];

    longint            level_fx;
    logic [15:0]       goal_lvl;
    longint            delta_fx;
    logic              fade_on;

    fade_word_t        duty_queue [$];

    initial begin
        mismatches  = 0;
        level_fx    = 0;
        goal_lvl    = '0;
        delta_fx    = 0;
        fade_on     = 1'b0;
        for (int i = 0; i < LUT_DEPTH; i++)
            duty_lut[GAMMA_INDEX_BITS'(i)] = gamma_floor(i);
    end

    // largest y in [0, 1e6] with y^5 * N^11 <= 1e30 * i^11
    function automatic logic [DUTY_W-1:0] gamma_floor(input int unsigned i);
        bit [255:0]  rhs;
        bit [255:0]  den;
        bit [255:0]  prod;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int          k;
        rhs = 256'd1;
        den = 256'd1;
        for (k = 0; k < 5; k++)
            rhs = rhs * 256'd1000000;
        for (k = 0; k < 11; k++)
        begin
            rhs = rhs * 256'(i);
            den = den * 256'(LUT_DEPTH - 1);
        end
        lo = 0;
        hi = 1000000;
        while (lo < hi)
        begin
            mid  = lo + (hi - lo + 1) / 2;
            prod = den;
            for (k = 0; k < 5; k++)
                prod = prod * 256'(mid);
            if (prod <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo[DUTY_W-1:0];
    endfunction

    function automatic fade_word_t advance_fader(input logic [CMD_W-1:0] op,
                                                 input logic [15:0] lvl,
                                                 input logic [15:0] dur);
        longint                      steps;
        longint                      diff;
        longint                      goal_fx;
        logic [15:0]                 whole;
        logic [GAMMA_INDEX_BITS-1:0] idx;
        fade_word_t                  word;
        case (op)
            CMD_FADE:
            begin
                steps = longint'(dur) / STEP_PERIOD_MS;
                if (steps < 1)
                    steps = 1;
                goal_lvl = lvl;
                diff     = (longint'(lvl) <<< 16) - level_fx;
                delta_fx = diff / steps;
                if (delta_fx == 0 && diff > 0)
                    delta_fx = 1;
                if (delta_fx == 0 && diff < 0)
                    delta_fx = -1;
                fade_on = 1'b1;
            end
            CMD_SET:
            begin
                fade_on  = 1'b0;
                goal_lvl = lvl;
                level_fx = longint'(lvl) <<< 16;
            end
            CMD_TICK:
            begin
                if (fade_on)
                begin
                    goal_fx  = longint'(goal_lvl) <<< 16;
                    level_fx = level_fx + delta_fx;
                    if ((delta_fx >= 0 && level_fx >= goal_fx) ||
                        (delta_fx < 0 && level_fx <= goal_fx))
                    begin
                        level_fx = goal_fx;
                        fade_on  = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        whole       = level_fx[31:16];
        idx         = whole[15 -: GAMMA_INDEX_BITS];
        word.duty   = duty_lut[idx];
        word.fading = fade_on;
        return word;
    endfunction

    always @(posedge clk)
    begin
        fade_word_t want;
        if (s_axis_tvalid && s_axis_tready)
            duty_queue.push_back(advance_fader(s_axis_tuser, s_axis_tdata[15:0],
                                               s_axis_tdata[31:16]));
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (duty_queue.size() == 0)
            begin
                $error("result word with no expected value pending");
                mismatches = mismatches + 1;
            end
            else
            begin
                want = duty_queue.pop_front();
                if (m_axis_tdata[19:0] !== want.duty)
                begin
                    $error("duty: expected %0d, got %0d", want.duty, m_axis_tdata[19:0]);
                    mismatches = mismatches + 1;
                end
                if (m_axis_tdata[20] !== want.fading)
                begin
                    $error("fading: expected %0d, got %0d", want.fading, m_axis_tdata[20]);
                    mismatches = mismatches + 1;
                end
            end
        end
        outstanding <= duty_queue.size();
    end

endmodule

>>> verif/gamma_corrected_fade_ramp_tb.sv
`timescale 1ns / 100ps

module gamma_corrected_fade_ramp_tb;
    import gcfr_pkg::*;

    localparam int STEP_MS        = 20;
    localparam int INDEX_BITS     = 10;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int RANDOM_ITEMS   = 800;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 150;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    int          fail_count;
    int          pending_count;
    int          quiet_cycles  = 0;
    int          sent_items    = 0;
    int          calm_tx       = 0;
    int          calm_rx       = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    gamma_corrected_fade_ramp #(
        .STEP_PERIOD_MS   (STEP_MS),
        .GAMMA_INDEX_BITS (INDEX_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    fade_ramp_checker #(
        .STEP_PERIOD_MS   (STEP_MS),
        .GAMMA_INDEX_BITS (INDEX_BITS)
    ) checker_i (
        .clk           (clk),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (fail_count),
        .outstanding   (pending_count)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    // hold tvalid across back-to-back words; drop it only ahead of a gap
    task automatic send_word(input logic [CMD_W-1:0] op, input logic [15:0] lvl,
                             input logic [15:0] dur, input bit counted);
        int gap;
        gap = draw_gap(calm_tx);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {dur, lvl};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (counted)
            sent_items++;
    endtask

    initial
    begin
        int stall;
        int taken;
        bit held;
        taken = 0;
        held  = 1'b0;
        wait (rst_n);
        forever
        begin
            stall = draw_gap(calm_rx);
            if (!held && taken == HOLD_AFTER)
            begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            taken++;
        end
    end

    initial
    begin
        int               pick;
        int               steps;
        int               ticks;
        int               n;
        logic [15:0]      target;
        logic [15:0]      dur;
        logic [CMD_W-1:0] op;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_word(CMD_TICK, 16'h0000, 16'h0000, 1'b1);
        send_word(CMD_SPARE, 16'hFFFF, 16'hFFFF, 1'b1);
        send_word(CMD_SET, 16'hFFFF, 16'h0000, 1'b1);
        send_word(CMD_TICK, 16'hFFFF, 16'hFFFF, 1'b1);
        send_word(CMD_SET, 16'h0000, 16'hFFFF, 1'b1);
        send_word(CMD_FADE, 16'hFFFF, 16'h0000, 1'b1);
        send_word(CMD_TICK, 16'h0000, 16'h0000, 1'b1);
        send_word(CMD_FADE, 16'h0000, 16'd19, 1'b1);
        send_word(CMD_TICK, 16'h0000, 16'h0000, 1'b1);
        send_word(CMD_FADE, 16'h0000, 16'd100, 1'b1);
        send_word(CMD_TICK, 16'h0000, 16'h0000, 1'b1);
        // delta truncates to zero upward: force +1
        send_word(CMD_SET, 16'h0001, 16'h0000, 1'b1);
        send_word(CMD_FADE, 16'h0000, 16'hFFFF, 1'b1);
        send_word(CMD_TICK, 16'h0000, 16'h0000, 1'b1);
        send_word(CMD_FADE, 16'h0001, 16'hFFFF, 1'b1);
        send_word(CMD_TICK, 16'h0000, 16'h0000, 1'b1);
        send_word(CMD_TICK, 16'h0000, 16'h0000, 1'b1);
        // delta truncates to zero downward: force -1
        send_word(CMD_SET, 16'h0000, 16'h0000, 1'b1);
        send_word(CMD_FADE, 16'h0001, 16'hFFFF, 1'b1);
        send_word(CMD_TICK, 16'h0000, 16'h0000, 1'b1);
        send_word(CMD_FADE, 16'h0000, 16'hFFFF, 1'b1);
        send_word(CMD_TICK, 16'h0000, 16'h0000, 1'b1);
        // restart a running fade, then cut it with a set
        send_word(CMD_FADE, 16'd40000, 16'd200, 1'b1);
        send_word(CMD_TICK, 16'h0000, 16'h0000, 1'b1);
        send_word(CMD_SET, 16'h8000, 16'h0000, 1'b1);

        sent_items = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 6)
            begin
                target = 16'($urandom);
                dur    = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 800));
                send_word(CMD_FADE, target, dur, 1'b1);
                steps = dur / STEP_MS;
                if (steps < 1)
                    steps = 1;
                ticks = steps + $urandom_range(0, 2);
                if (ticks > 45)
                    ticks = 45;
                for (n = 0; n < ticks; n++)
                begin
                    if ($urandom_range(0, 24) == 0)
                    begin
                        op = CMD_W'($urandom_range(0, 3));
                        send_word(op, 16'($urandom), 16'($urandom), op != CMD_SPARE);
                    end
                    else
                        send_word(CMD_TICK, 16'($urandom), 16'($urandom), 1'b1);
                end
            end
            else if (pick == 7)
            begin
                send_word(CMD_SET, 16'($urandom), 16'($urandom), 1'b1);
                repeat ($urandom_range(1, 3))
                    send_word(CMD_TICK, 16'($urandom), 16'($urandom), 1'b0);
            end
            else if (pick == 8)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    op = CMD_W'($urandom_range(0, 3));
                    send_word(op, 16'($urandom), 16'($urandom), op != CMD_SPARE);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    op = ($urandom_range(0, 1) == 0) ? CMD_TICK : CMD_SPARE;
                    send_word(op, 16'($urandom), 16'($urandom), 1'b0);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
